### rtl/core/rounded_rect_shadow_alpha_defines.svh
// assertion macros for the rounded rectangle shadow alpha block
`ifndef ROUNDED_RECT_SHADOW_ALPHA_DEFINES_SVH
`define ROUNDED_RECT_SHADOW_ALPHA_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is applied
`define RRSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked during reset
`define RRSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRSA_ASSERT(lbl, prop, msg)
`define RRSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/rrsa_pkg.sv
// shared types, constants and tables of the shadow alpha block
package rrsa_pkg;

  localparam int CORNER_RADIUS_DEF = 8;

  localparam int PIX_W      = 12;
  localparam int DIST_W     = 17;
  localparam int ROOT_W     = 18;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int ALPHA_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTENT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_SIZE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_ALPHA     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y       = 3'd7;

  // 2x2 ordered dither thresholds, indexed by {row lsb, column lsb}
  localparam logic [ALPHA_W-1:0] DITHER_THR [4] = '{8'd0, 8'd32, 8'd48, 8'd16};

  typedef struct packed {
    logic signed [12:0] content_left;
    logic signed [12:0] content_top;
    logic [11:0]        content_width;
    logic [11:0]        content_height;
    logic [7:0]         shadow_size;
    logic [7:0]         peak_alpha;
    logic signed [8:0]  offset_x;
    logic signed [8:0]  offset_y;
  } cfg_t;

  // per-pixel data that rides alongside the squared distance
  typedef struct packed {
    logic              live;
    logic              corner;
    logic              x0;
    logic              y0;
    logic [DIST_W-1:0] edge_dist;
    logic [DIST_W-1:0] eff;
  } geo_side_t;

endpackage

### rtl/core/rrsa_geom.sv
// shadow box test, edge offsets, effective radius and squared corner distance
module rrsa_geom #(
  parameter int CORNER_RADIUS = rrsa_pkg::CORNER_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  rrsa_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  input  logic [rrsa_pkg::PIX_W-1:0]  in_x,
  input  logic [rrsa_pkg::PIX_W-1:0]  in_y,
  output logic                        out_valid,
  output logic [rrsa_pkg::RAD_W-1:0]  out_rad,
  output rrsa_pkg::geo_side_t         out_side
);

  localparam int DW = rrsa_pkg::DIST_W;
  localparam logic signed [23:0] CR24 = 24'(CORNER_RADIUS * 128);
  localparam logic [DW-1:0]      CR17 = DW'(CORNER_RADIUS * 128);

  // displaced origin, to be held fixed by the user while pixels flow (the block does not enforce it)
  logic signed [15:0] sx16, sy16;
  assign sx16 = 16'(cfg.content_left) + 16'(cfg.offset_x);
  assign sy16 = 16'(cfg.content_top) + 16'(cfg.offset_y);

  // stage 1: shadow box test
  logic signed [15:0] ss16, oxn, oxp, oyn, oyp, bl, br, bt, bb, xs, ys;
  logic               hit;
  always_comb begin
    ss16 = $signed({8'b0, cfg.shadow_size});
    oxn  = (cfg.offset_x < 0) ? -16'(cfg.offset_x) : 16'sd0;
    oxp  = (cfg.offset_x > 0) ? 16'(cfg.offset_x) : 16'sd0;
    oyn  = (cfg.offset_y < 0) ? -16'(cfg.offset_y) : 16'sd0;
    oyp  = (cfg.offset_y > 0) ? 16'(cfg.offset_y) : 16'sd0;
    bl   = sx16 - ss16 - oxn;
    br   = sx16 + $signed({4'b0, cfg.content_width}) + ss16 + oxp;
    bt   = sy16 - ss16 - oyn;
    bb   = sy16 + $signed({4'b0, cfg.content_height}) + ss16 + oyp;
    xs   = $signed({4'b0, in_x});
    ys   = $signed({4'b0, in_y});
    hit  = (cfg.shadow_size != 8'd0) && (xs >= bl) && (xs < br) && (ys >= bt) && (ys < bb);
  end

  logic                        s1_valid_r, s1_hit_r;
  logic [rrsa_pkg::PIX_W-1:0]  s1_x_r, s1_y_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_hit_r <= hit;
      s1_x_r   <= in_x;
      s1_y_r   <= in_y;
    end
  end

  // stage 2: axis distances to the inset rectangle and effective radius
  logic signed [23:0] l24, r24, t24, b24, il, ir, it, ib, px, py, dxw, dyw;
  logic signed [9:0]  tx, ty;
  logic signed [19:0] ss128, effw;
  logic [DW-1:0]      dx, dy, mx, e_dist, eff;
  always_comb begin
    l24 = 24'(sx16) <<< 7;
    t24 = 24'(sy16) <<< 7;
    r24 = l24 + $signed({5'b0, cfg.content_width, 7'b0});
    b24 = t24 + $signed({5'b0, cfg.content_height, 7'b0});
    il  = l24 + CR24;
    ir  = r24 - CR24;
    it  = t24 + CR24;
    ib  = b24 - CR24;
    px  = $signed({5'b0, s1_x_r, 7'h40});
    py  = $signed({5'b0, s1_y_r, 7'h40});
    if (px < il) begin
      dxw = il - px;
    end else if (px > ir) begin
      dxw = px - ir;
    end else begin
      dxw = 24'sd0;
    end
    if (py < it) begin
      dyw = it - py;
    end else if (py > ib) begin
      dyw = py - ib;
    end else begin
      dyw = 24'sd0;
    end
    dx = dxw[DW-1:0];
    dy = dyw[DW-1:0];
    // side signs pick the offset that lengthens the falloff
    if (px < l24) begin
      tx = -10'(cfg.offset_x);
    end else if (px > r24) begin
      tx = 10'(cfg.offset_x);
    end else begin
      tx = 10'sd0;
    end
    if (py < t24) begin
      ty = -10'(cfg.offset_y);
    end else if (py > b24) begin
      ty = 10'(cfg.offset_y);
    end else begin
      ty = 10'sd0;
    end
    ss128 = $signed({5'b0, cfg.shadow_size, 7'b0});
    effw  = ss128 + (20'(tx) <<< 7) + (20'(ty) <<< 7);
    if (effw < ss128) begin
      effw = ss128;
    end
    eff    = effw[DW-1:0];
    mx     = (dx > dy) ? dx : dy;
    e_dist = (mx > CR17) ? (mx - CR17) : '0;
  end

  logic                s2_valid_r;
  logic [DW-1:0]       s2_dx_r, s2_dy_r;
  rrsa_pkg::geo_side_t s2_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx_r             <= dx;
      s2_dy_r             <= dy;
      s2_side_r.live      <= s1_hit_r;
      s2_side_r.corner    <= (dx != '0) && (dy != '0);
      s2_side_r.x0        <= s1_x_r[0];
      s2_side_r.y0        <= s1_y_r[0];
      s2_side_r.edge_dist <= e_dist;
      s2_side_r.eff       <= eff;
    end
  end

  // stage 3: squares
  logic                s3_valid_r;
  logic [2*DW-1:0]     s3_dxx_r, s3_dyy_r;
  rrsa_pkg::geo_side_t s3_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_dxx_r  <= s2_dx_r * s2_dx_r;
      s3_dyy_r  <= s2_dy_r * s2_dy_r;
      s3_side_r <= s2_side_r;
    end
  end

  // stage 4: sum of squares
  logic                       s4_valid_r;
  logic [rrsa_pkg::RAD_W-1:0] s4_rad_r;
  rrsa_pkg::geo_side_t        s4_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= s3_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4_rad_r  <= rrsa_pkg::RAD_W'(s3_dxx_r) + rrsa_pkg::RAD_W'(s3_dyy_r);
      s4_side_r <= s3_side_r;
    end
  end

  assign out_valid = s4_valid_r;
  assign out_rad   = s4_rad_r;
  assign out_side  = s4_side_r;

endmodule

### rtl/core/rrsa_sqrt.sv
// pipelined floor square root, one result bit per stage
module rrsa_sqrt #(
  parameter int RW = rrsa_pkg::ROOT_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  logic            vld_r  [RW];
  logic [2*RW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   side_r [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int BI = RW - 1 - g;
    logic            vld_in;
    logic [2*RW-1:0] rem_in, trial;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    // (root + 2^b)^2 - root^2
    assign trial = ((2*RW)'(root_in) << (BI + 1)) | ((2*RW)'(1) << (2 * BI));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= side_in;
        if (rem_in >= trial) begin
          rem_r[g]  <= rem_in - trial;
          root_r[g] <= root_in | (RW'(1) << BI);
        end else begin
          rem_r[g]  <= rem_in;
          root_r[g] <= root_in;
        end
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

### rtl/core/rrsa_div.sv
// pipelined restoring divider for a short quotient, one quotient bit per stage
module rrsa_div #(
  parameter int NW = 25,
  parameter int DW = 17,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  localparam int WW = DW + QW;

  logic          vld_r  [QW];
  logic [WW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int BI = QW - 1 - g;
    logic          vld_in;
    logic [WW-1:0] rem_in, trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;

    if (g == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = WW'(in_num);
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign den_in  = den_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign trial = WW'(den_in) << BI;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g]  <= den_in;
        side_r[g] <= side_in;
        if (rem_in >= trial) begin
          rem_r[g] <= rem_in - trial;
          quo_r[g] <= quo_in | (QW'(1) << BI);
        end else begin
          rem_r[g] <= rem_in;
          quo_r[g] <= quo_in;
        end
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_den   = den_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

### rtl/core/rrsa_falloff.sv
// rounded distance, quadratic falloff, dither and result register
module rrsa_falloff #(
  parameter int CORNER_RADIUS = rrsa_pkg::CORNER_RADIUS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [rrsa_pkg::ALPHA_W-1:0] peak_alpha,
  input  logic                         in_valid,
  input  logic [rrsa_pkg::ROOT_W-1:0]  in_root,
  input  rrsa_pkg::geo_side_t          in_side,
  output logic                         out_valid,
  output logic                         out_we,
  output logic [rrsa_pkg::ALPHA_W-1:0] out_alpha
);

  localparam int DW = rrsa_pkg::DIST_W;
  localparam int AW = rrsa_pkg::ALPHA_W;
  localparam int PW = DW + AW;
  localparam logic [rrsa_pkg::ROOT_W-1:0] CR18 = rrsa_pkg::ROOT_W'(CORNER_RADIUS * 128);

  typedef struct packed {
    logic          live;
    logic          x0;
    logic          y0;
    logic [DW-1:0] tt;
  } div1_side_t;

  typedef struct packed {
    logic live;
    logic x0;
    logic y0;
  } div2_side_t;

  // stage f1: distance, falloff range check, remaining length
  logic [rrsa_pkg::ROOT_W-1:0] root_m;
  logic [DW-1:0]               rdist;
  logic                        in_range;
  always_comb begin
    root_m   = (in_root > CR18) ? (in_root - CR18) : '0;
    rdist    = in_side.corner ? root_m[DW-1:0] : in_side.edge_dist;
    in_range = in_side.live && (rdist != '0) && (rdist < in_side.eff);
  end

  logic          f1_valid_r;
  div1_side_t    f1_side_r;
  logic [DW-1:0] f1_eff_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f1_side_r.live <= in_range;
      f1_side_r.x0   <= in_side.x0;
      f1_side_r.y0   <= in_side.y0;
      f1_side_r.tt   <= in_side.eff - rdist;
      f1_eff_r       <= in_side.eff;
    end
  end

  // stage f2: peak times remaining length
  logic          f2_valid_r;
  logic [PW-1:0] f2_prod_r;
  div1_side_t    f2_side_r;
  logic [DW-1:0] f2_eff_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f2_valid_r <= f1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f2_prod_r <= peak_alpha * f1_side_r.tt;
      f2_side_r <= f1_side_r;
      f2_eff_r  <= f1_eff_r;
    end
  end

  // first division by the effective radius
  logic          d1_valid;
  logic [AW-1:0] d1_quo;
  logic [DW-1:0] d1_den;
  div1_side_t    d1_side;
  rrsa_div #(.NW(PW), .DW(DW), .QW(AW), .SW($bits(div1_side_t))) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f2_valid_r),
    .in_num    (f2_prod_r),
    .in_den    (f2_eff_r),
    .in_side   (f2_side_r),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_den   (d1_den),
    .out_side  (d1_side)
  );

  // stage f3: partial alpha times remaining length
  logic          f3_valid_r;
  logic [PW-1:0] f3_prod_r;
  logic [DW-1:0] f3_eff_r;
  div2_side_t    f3_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_valid_r <= 1'b0;
    end else if (en) begin
      f3_valid_r <= d1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f3_prod_r      <= d1_quo * d1_side.tt;
      f3_eff_r       <= d1_den;
      f3_side_r.live <= d1_side.live;
      f3_side_r.x0   <= d1_side.x0;
      f3_side_r.y0   <= d1_side.y0;
    end
  end

  // second division by the effective radius
  logic          d2_valid;
  logic [AW-1:0] d2_quo;
  logic [DW-1:0] d2_den;
  div2_side_t    d2_side;
  rrsa_div #(.NW(PW), .DW(DW), .QW(AW), .SW($bits(div2_side_t))) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f3_valid_r),
    .in_num    (f3_prod_r),
    .in_den    (f3_eff_r),
    .in_side   (f3_side_r),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_den   (d2_den),
    .out_side  (d2_side)
  );

  // final stage: dither against the 2x2 threshold and result register
  logic [AW-1:0] thr;
  logic          we_nxt;
  always_comb begin
    thr    = rrsa_pkg::DITHER_THR[{d2_side.y0, d2_side.x0}];
    we_nxt = d2_side.live && (d2_quo != '0) && (d2_quo >= thr) && (d2_den != '0);
  end

  logic          out_valid_r, out_we_r;
  logic [AW-1:0] out_alpha_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_we_r    <= we_nxt;
      out_alpha_r <= we_nxt ? d2_quo : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_we    = out_we_r;
  assign out_alpha = out_alpha_r;

endmodule

### rtl/core/rounded_rect_shadow_alpha.sv
// Drop-shadow alpha for a rounded rectangle: takes one pixel per clock and
// returns one result per pixel, in order. Most of the pipeline lies in the
// 18-stage square root of the corner distance and the two 8-stage dividers
// of the falloff; all stages move together, so a pixel is accepted whenever
// the result register is empty or being taken. The configuration registers
// are written through the cfg port and must only be changed while no pixel
// is in flight.
module rounded_rect_shadow_alpha #(
  parameter int CORNER_RADIUS = rrsa_pkg::CORNER_RADIUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel requests
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // pixel_x[11:0], pixel_y[23:12]
  // shadow results
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // shadow_alpha[7:0]
  output logic [0:0]                      out_tuser,  // write_enable[0]
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrsa_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "rounded_rect_shadow_alpha_defines.svh"

  // configuration registers
  rrsa_pkg::cfg_t cfg_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rrsa_pkg::REG_CONTENT_LEFT:   cfg_r.content_left   <= $signed(cfg_data[12:0]);
        rrsa_pkg::REG_CONTENT_TOP:    cfg_r.content_top    <= $signed(cfg_data[12:0]);
        rrsa_pkg::REG_CONTENT_WIDTH:  cfg_r.content_width  <= cfg_data[11:0];
        rrsa_pkg::REG_CONTENT_HEIGHT: cfg_r.content_height <= cfg_data[11:0];
        rrsa_pkg::REG_SHADOW_SIZE:    cfg_r.shadow_size    <= cfg_data[7:0];
        rrsa_pkg::REG_PEAK_ALPHA:     cfg_r.peak_alpha     <= cfg_data[7:0];
        rrsa_pkg::REG_OFFSET_X:       cfg_r.offset_x       <= $signed(cfg_data[8:0]);
        rrsa_pkg::REG_OFFSET_Y:       cfg_r.offset_y       <= $signed(cfg_data[8:0]);
        default: ;
      endcase
    end
  end

  // pipeline advance: result register free or being taken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic                       g_valid;
  logic [rrsa_pkg::RAD_W-1:0] g_rad;
  rrsa_pkg::geo_side_t        g_side;
  rrsa_geom #(.CORNER_RADIUS(CORNER_RADIUS)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_x      (in_tdata[11:0]),
    .in_y      (in_tdata[23:12]),
    .out_valid (g_valid),
    .out_rad   (g_rad),
    .out_side  (g_side)
  );

  logic                        q_valid;
  logic [rrsa_pkg::ROOT_W-1:0] q_root;
  rrsa_pkg::geo_side_t         q_side;
  rrsa_sqrt #(.RW(rrsa_pkg::ROOT_W), .SW($bits(rrsa_pkg::geo_side_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_valid),
    .in_rad    (g_rad),
    .in_side   (g_side),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  rrsa_falloff #(.CORNER_RADIUS(CORNER_RADIUS)) u_falloff (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .peak_alpha (cfg_r.peak_alpha),
    .in_valid   (q_valid),
    .in_root    (q_root),
    .in_side    (q_side),
    .out_valid  (out_tvalid),
    .out_we     (out_tuser[0]),
    .out_alpha  (out_tdata)
  );

  `RRSA_ASSERT(a_skip_zero, out_tvalid && !out_tuser[0] |-> out_tdata == 8'd0, "skipped pixel carries alpha")
  `RRSA_ASSERT(a_stall_holds_input, out_tvalid && !out_tready |-> !in_tready, "request taken during stall")
  `RRSA_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule
